// ===== rtl/jesu_pkg.sv =====
// ---------------------------------------------------------------------------
// jesu_pkg
// types, character codes and helpers shared by the json escape / utf-8
// sanitizer controller, datapath and top level
// ---------------------------------------------------------------------------
package jesu_pkg;

	// request from the source side: one raw string byte
	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} req_t;

	// request to the sink side: one escaped byte or an empty end marker
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       string_end;
	} res_t;

	// controller states
	typedef enum logic {
		ST_PROC,
		ST_EMIT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic eval;
		logic emit;
		logic flush;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic q_empty;
		logic open;
		logic flush_out;
		logic out_free;
		logic hold_v;
		logic eval_run;
		logic run_end;
	} stat_t;

	// work queue and run buffer sizes
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned RUN_MAX = 6;

	// character codes
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CTRL_LIM  = 8'h20;

	// lower-case hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'h0, nib};
		end else begin
			r = 8'h57 + {4'h0, nib};
		end
		return r;
	endfunction

	// extra bytes a utf-8 lead needs, 0 when not a lead
	function automatic logic [1:0] lead_extra(input logic [7:0] b);
		logic [1:0] r;
		if ((b & 8'hE0) == 8'hC0) begin
			r = 2'd1;
		end else if ((b & 8'hF0) == 8'hE0) begin
			r = 2'd2;
		end else if ((b & 8'hF8) == 8'hF0) begin
			r = 2'd3;
		end else begin
			r = 2'd0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/jesu_ctrl.sv =====
// ---------------------------------------------------------------------------
// jesu_ctrl
// sequencing state machine: evaluate queued bytes, emit runs, close requests
// ---------------------------------------------------------------------------
module jesu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            raw_valid,
	output logic            raw_stall,
	input  jesu_pkg::stat_t stat,
	output jesu_pkg::cmd_t  cmd
);
	import jesu_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_PROC;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_PROC: begin
				if (!stat.q_empty && stat.eval_run) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if ((!stat.hold_v || stat.out_free) && stat.run_end) begin
					state_d = ST_PROC;
				end
			end
			default: state_d = ST_PROC;
		endcase
	end

	// outputs
	always_comb begin
		cmd   = '0;
		ready = 1'b0;
		case (state_q)
			ST_PROC: begin
				if (!stat.q_empty) begin
					cmd.eval = 1'b1;
				end else if (stat.open) begin
					ready     = !stat.flush_out || stat.out_free;
					cmd.flush = ready;
				end else begin
					ready = 1'b1;
				end
			end
			ST_EMIT: begin
				cmd.emit = !stat.hold_v || stat.out_free;
			end
			default: begin
				ready = 1'b0;
			end
		endcase
		cmd.accept = ready && raw_valid;
	end

	assign raw_stall = !ready;

endmodule

// ===== rtl/jesu_dp.sv =====
// ---------------------------------------------------------------------------
// jesu_dp
// datapath: work queue, pending utf-8 sequence, run buffer, lookahead and
// output register
// ---------------------------------------------------------------------------
module jesu_dp (
	input  logic            clk,
	input  logic            arst_n,
	input  jesu_pkg::req_t  raw_data,
	input  jesu_pkg::cmd_t  cmd,
	input  logic            esc_stall,
	output jesu_pkg::stat_t stat,
	output logic            esc_valid,
	output jesu_pkg::res_t  esc_data
);
	import jesu_pkg::*;

	// work queue of bytes still to run through the escaper
	logic [7:0] q_byte_q [QDEPTH];
	logic       q_last_q [QDEPTH];
	logic [2:0] q_cnt_q;

	// pending utf-8 sequence
	logic [7:0] pend_q [4];
	logic [2:0] pcnt_q;
	logic [1:0] pext_q;

	// run buffer
	logic [7:0] run_q [RUN_MAX];
	logic [2:0] run_len_q;
	logic [2:0] run_idx_q;

	// one byte lookahead so the last byte of a request can be marked
	logic [7:0] hold_q;
	logic       hold_v_q;

	logic       open_q;
	logic       step_last_q;

	res_t       out_q;
	logic       out_v_q;

	// evaluation of the queue head
	logic [7:0] b;
	logic       l;
	logic [1:0] slot;
	logic [1:0] n;
	logic [1:0] ext;
	logic [7:0] held [4];
	logic       held_last [4];
	logic       ok;
	logic [7:0] ev_run [RUN_MAX];
	logic [2:0] ev_len;
	logic [2:0] nx_pcnt;
	logic [1:0] nx_pext;
	logic       pend_we;
	logic [1:0] pend_wa;
	logic       ev_push;
	logic [7:0] nq_byte [QDEPTH];
	logic       nq_last [QDEPTH];
	logic [2:0] nq_cnt;
	logic       out_free;
	logic       out_load;
	res_t       out_d;

	always_comb begin
		b       = q_byte_q[0];
		l       = q_last_q[0];
		slot    = pcnt_q[1:0];
		n       = pext_q;
		ext     = lead_extra(b);
		ev_len  = 3'd0;
		nx_pcnt = pcnt_q;
		nx_pext = pext_q;
		pend_we = 1'b0;
		pend_wa = slot;
		ev_push = 1'b0;
		ok      = 1'b1;
		for (int k = 0; k < RUN_MAX; k++) begin
			ev_run[k] = 8'h00;
		end
		for (int k = 0; k < 4; k++) begin
			held[k]      = (2'(k) == slot) ? b : pend_q[k];
			held_last[k] = (2'(k) == slot) ? l : 1'b0;
		end
		for (int k = 1; k < 4; k++) begin
			if ((2'(k) <= n) && (held[k][7:6] != 2'b10)) begin
				ok = 1'b0;
			end
		end

		if (pcnt_q == 3'd0) begin
			pend_wa = 2'd0;
			case (b)
				CH_QUOTE: begin
					ev_run[0] = CH_BSLASH;
					ev_run[1] = CH_QUOTE;
					ev_len    = 3'd2;
				end
				CH_BSLASH: begin
					ev_run[0] = CH_BSLASH;
					ev_run[1] = CH_BSLASH;
					ev_len    = 3'd2;
				end
				CH_LF: begin
					ev_run[0] = CH_BSLASH;
					ev_run[1] = CH_N;
					ev_len    = 3'd2;
				end
				CH_CR: begin
					ev_len = 3'd0;
				end
				CH_TAB: begin
					ev_run[0] = CH_BSLASH;
					ev_run[1] = CH_T;
					ev_len    = 3'd2;
				end
				default: begin
					if (b < CTRL_LIM) begin
						ev_run[0] = CH_BSLASH;
						ev_run[1] = CH_U;
						ev_run[2] = CH_ZERO;
						ev_run[3] = CH_ZERO;
						ev_run[4] = hex_digit(b[7:4]);
						ev_run[5] = hex_digit(b[3:0]);
						ev_len    = 3'd6;
					end else if (!b[7]) begin
						ev_run[0] = b;
						ev_len    = 3'd1;
					end else if (ext != 2'd0 && !l) begin
						pend_we = 1'b1;
						nx_pcnt = 3'd1;
						nx_pext = ext;
					end else begin
						ev_run[0] = CH_QMARK;
						ev_len    = 3'd1;
					end
				end
			endcase
		end else begin
			pend_we = 1'b1;
			if (pcnt_q == {1'b0, n}) begin
				// sequence complete
				nx_pcnt = 3'd0;
				nx_pext = 2'd0;
				if (ok) begin
					for (int k = 0; k < 4; k++) begin
						ev_run[k] = held[k];
					end
					ev_len = {1'b0, n} + 3'd1;
				end else begin
					ev_run[0] = CH_QMARK;
					ev_len    = 3'd1;
					ev_push   = 1'b1;
				end
			end else if (l) begin
				// string ends inside a sequence
				ev_run[0] = CH_QMARK;
				ev_len    = 3'd1;
				nx_pcnt   = 3'd0;
				nx_pext   = 2'd0;
			end else begin
				nx_pcnt = pcnt_q + 3'd1;
			end
		end
	end

	// queue after popping the head, with replayed bytes in front when broken
	always_comb begin
		logic [2:0] src;
		logic [1:0] idx;
		src = 3'd0;
		idx = 2'd0;
		for (int i = 0; i < QDEPTH; i++) begin
			src = ev_push ? (3'(i) - {1'b0, n}) : 3'(i);
			idx = src[1:0] + 2'd1;
			if (ev_push && (3'(i) < {1'b0, n})) begin
				nq_byte[i] = held[2'(i + 1)];
				nq_last[i] = held_last[2'(i + 1)];
			end else if (src < 3'(QDEPTH - 1)) begin
				nq_byte[i] = q_byte_q[idx];
				nq_last[i] = q_last_q[idx];
			end else begin
				nq_byte[i] = 8'h00;
				nq_last[i] = 1'b0;
			end
		end
		nq_cnt = ev_push ? (q_cnt_q - 3'd1 + {1'b0, n}) : (q_cnt_q - 3'd1);
	end

	// output register loading
	assign out_free = !out_v_q || !esc_stall;

	always_comb begin
		out_d    = '0;
		out_load = 1'b0;
		if (cmd.emit && hold_v_q) begin
			out_load          = 1'b1;
			out_d.out_byte    = hold_q;
			out_d.has_byte    = 1'b1;
		end else if (cmd.flush && hold_v_q) begin
			out_load          = 1'b1;
			out_d.out_byte    = hold_q;
			out_d.has_byte    = 1'b1;
			out_d.run_last    = 1'b1;
			out_d.string_end  = step_last_q;
		end else if (cmd.flush && step_last_q) begin
			out_load          = 1'b1;
			out_d.run_last    = 1'b1;
			out_d.string_end  = 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q     <= 3'd0;
			pcnt_q      <= 3'd0;
			pext_q      <= 2'd0;
			run_len_q   <= 3'd0;
			run_idx_q   <= 3'd0;
			hold_v_q    <= 1'b0;
			open_q      <= 1'b0;
			step_last_q <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (cmd.accept) begin
				q_cnt_q     <= 3'd1;
				open_q      <= 1'b1;
				step_last_q <= raw_data.in_last;
			end else if (cmd.eval) begin
				q_cnt_q <= nq_cnt;
			end
			if (cmd.flush && !cmd.accept) begin
				open_q <= 1'b0;
			end
			if (cmd.eval) begin
				pcnt_q    <= nx_pcnt;
				pext_q    <= nx_pext;
				run_len_q <= ev_len;
				run_idx_q <= 3'd0;
			end else if (cmd.emit) begin
				run_idx_q <= run_idx_q + 3'd1;
			end
			if (cmd.emit) begin
				hold_v_q <= 1'b1;
			end else if (cmd.flush) begin
				hold_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (!esc_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			q_byte_q[0] <= raw_data.in_byte;
			q_last_q[0] <= raw_data.in_last;
		end else if (cmd.eval) begin
			for (int i = 0; i < QDEPTH; i++) begin
				q_byte_q[i] <= nq_byte[i];
				q_last_q[i] <= nq_last[i];
			end
		end
		if (cmd.eval && pend_we) begin
			pend_q[pend_wa] <= b;
		end
		if (cmd.eval) begin
			for (int k = 0; k < RUN_MAX; k++) begin
				run_q[k] <= ev_run[k];
			end
		end
		if (cmd.emit) begin
			hold_q <= run_q[run_idx_q];
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign stat.q_empty   = (q_cnt_q == 3'd0);
	assign stat.open      = open_q;
	assign stat.flush_out = hold_v_q || step_last_q;
	assign stat.out_free  = out_free;
	assign stat.hold_v    = hold_v_q;
	assign stat.eval_run  = (ev_len != 3'd0);
	assign stat.run_end   = (run_idx_q == run_len_q - 3'd1);

	assign esc_valid = out_v_q;
	assign esc_data  = out_q;

endmodule

// ===== rtl/json_escape_utf8_sanitizer_unit.sv =====
// ---------------------------------------------------------------------------
// json_escape_utf8_sanitizer_unit
// json string escaper with utf-8 sequence sanitizing, one source byte per
// request
// ---------------------------------------------------------------------------
// Each raw byte request yields its json-escaped output bytes on the esc
// channel, the last one flagged run_last and, for the final byte of the
// string, string_end; a final byte that produces nothing gives one empty
// marker (has_byte low). Flow: every byte that passes through the escaper
// (the request byte plus any bytes replayed from a broken utf-8 sequence)
// is evaluated in turn, each output byte is walked out of the run buffer,
// and a closing step finishes the request while the next request is taken
// in; a new request is held off until the last one has been walked out. The
// throughput is set by the single evaluate/emit sequencer and its
// one-byte-per-cycle output path, which esc_stall can hold.
// No clearing pass is needed after reset.
module json_escape_utf8_sanitizer_unit (
	input  logic           clk,
	input  logic           arst_n,
	// raw string bytes
	input  logic           raw_valid,
	output logic           raw_stall,
	input  jesu_pkg::req_t raw_data,
	// escaped bytes
	output logic           esc_valid,
	input  logic           esc_stall,
	output jesu_pkg::res_t esc_data
);
	import jesu_pkg::*;

	// command and status between sequencer and datapath
	cmd_t  cmd;
	stat_t stat;

	// sequencer: evaluate queue head, walk the run buffer, close the request
	jesu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: work queue, pending sequence, run buffer, output register
	jesu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_data  (raw_data),
		.cmd       (cmd),
		.esc_stall (esc_stall),
		.stat      (stat),
		.esc_valid (esc_valid),
		.esc_data  (esc_data)
	);

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the json escape / utf-8 sanitizer unit
// ---------------------------------------------------------------------------
// Raw string bytes go in on the raw channel and escaped bytes come out on
// the esc channel. A bit-accurate escaper in the bench predicts the output
// run of every accepted request. Results are checked field by field in
// order. Stimulus starts with a directed set covering escapes, control
// bytes, complete, broken, stray and truncated utf-8 sequences, and an empty
// end. It then moves on to random strings, mostly well formed with random
// content and partly noise. Both sides idle at random, the receiver holds
// off for long stretches, and the sender sometimes waits for a full drain.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import jesu_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned RANDOM_ITEMS = 330;
	localparam int unsigned SETTLE       = 100;
	localparam int unsigned RUN_CAP      = 24;
	localparam int unsigned CHOKE_LEN    = 300;
	localparam logic [7:0]  CH_LOWER_A   = 8'h61;

	// one queued raw request plus a flag telling the driver to drain first
	typedef struct packed {
		logic drain_first;
		req_t req;
	} raw_item_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic raw_valid = 1'b0;
	logic raw_stall;
	req_t raw_data  = '0;
	logic esc_valid;
	logic esc_stall = 1'b0;
	res_t esc_data;

	json_escape_utf8_sanitizer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_data  (raw_data),
		.esc_valid (esc_valid),
		.esc_stall (esc_stall),
		.esc_data  (esc_data)
	);

	// 8 ns clock
	initial begin
		forever #4 clk = ~clk;
	end

	// reset held at the start, released once
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// shared bench state
	// ------------------------------------------------------------------
	raw_item_t   raw_pending[$];   // requests waiting for the driver
	res_t        escaped_due[$];   // predicted escaped results, oldest first
	logic        drained = 1'b1;   // nothing predicted is still outstanding
	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;
	int unsigned bytes_taken = 0;
	int unsigned results_checked = 0;
	int unsigned choke_count = 0;

	// predictor state: held utf-8 sequence
	logic [7:0] seq_buf[4];
	logic [2:0] seq_fill = '0;
	logic [1:0] seq_need = '0;

	// bytes of the current output run
	logic [7:0] run_bytes[$];

	// ------------------------------------------------------------------
	// escaper predictor
	// ------------------------------------------------------------------
	// append one byte to the run, capped at RUN_CAP bytes
	function automatic void put_out(input logic [7:0] c);
		if (run_bytes.size() < RUN_CAP) begin
			run_bytes.push_back(c);
		end
	endfunction

	// lower-case hex character for one nibble
	function automatic logic [7:0] nib_char(input logic [3:0] n);
		if (n < 4'd10) begin
			return CH_ZERO + 8'(n);
		end
		return CH_LOWER_A + 8'(n) - 8'd10;
	endfunction

	// works out the escaped results of one raw request and queues them;
	// bytes replayed from a broken sequence go to the front of the work
	// list so that they are handled before anything after them
	function automatic void escape_request(input req_t r);
		logic [7:0] work_byte[$];
		logic       work_last[$];
		logic [7:0] b;
		logic       lst;
		logic [1:0] need;
		logic [7:0] held[4];
		logic       ok;
		int         n;
		res_t       want;

		run_bytes.delete();
		work_byte.push_back(r.in_byte);
		work_last.push_back(r.in_last);
		while (work_byte.size() > 0) begin
			b   = work_byte.pop_front();
			lst = work_last.pop_front();
			if (seq_fill == 3'd0) begin
				case (b)
					CH_QUOTE: begin
						put_out(CH_BSLASH);
						put_out(CH_QUOTE);
					end
					CH_BSLASH: begin
						put_out(CH_BSLASH);
						put_out(CH_BSLASH);
					end
					CH_LF: begin
						put_out(CH_BSLASH);
						put_out(CH_N);
					end
					CH_TAB: begin
						put_out(CH_BSLASH);
						put_out(CH_T);
					end
					CH_CR: begin
						// carriage return is dropped
					end
					default: begin
						if (b < CTRL_LIM) begin
							put_out(CH_BSLASH);
							put_out(CH_U);
							put_out(CH_ZERO);
							put_out(CH_ZERO);
							put_out(nib_char(b[7:4]));
							put_out(nib_char(b[3:0]));
						end else if (!b[7]) begin
							put_out(b);
						end else begin
							casez (b)
								8'b110?????: need = 2'd1;
								8'b1110????: need = 2'd2;
								8'b11110???: need = 2'd3;
								default:     need = 2'd0;
							endcase
							if (need == 2'd0 || lst) begin
								// stray byte, or a lead that ends the string
								put_out(CH_QMARK);
							end else begin
								seq_buf[0] = b;
								seq_fill   = 3'd1;
								seq_need   = need;
							end
						end
					end
				endcase
			end else begin
				seq_buf[seq_fill[1:0]] = b;
				seq_fill = seq_fill + 3'd1;
				if (int'(seq_fill) >= int'(seq_need) + 1) begin
					held     = seq_buf;
					n        = int'(seq_need);
					seq_fill = '0;
					seq_need = '0;
					ok = 1'b1;
					for (int k = 1; k <= n; k++) begin
						if (held[k][7:6] != 2'b10) begin
							ok = 1'b0;
						end
					end
					if (ok) begin
						for (int k = 0; k <= n; k++) begin
							put_out(held[k]);
						end
					end else begin
						// broken: one '?', lead dropped, the rest replayed
						put_out(CH_QMARK);
						for (int k = n; k >= 1; k--) begin
							work_byte.push_front(held[k]);
							work_last.push_front(lst && k == n);
						end
					end
				end else if (lst) begin
					// string ended inside a sequence
					put_out(CH_QMARK);
					seq_fill = '0;
					seq_need = '0;
				end
			end
		end
		if (r.in_last) begin
			seq_fill = '0;
			seq_need = '0;
		end

		if (run_bytes.size() == 0) begin
			if (r.in_last) begin
				// empty end marker
				want.out_byte   = '0;
				want.has_byte   = 1'b0;
				want.run_last   = 1'b1;
				want.string_end = 1'b1;
				escaped_due.push_back(want);
			end
		end else begin
			foreach (run_bytes[i]) begin
				want.out_byte   = run_bytes[i];
				want.has_byte   = 1'b1;
				want.run_last   = (i == run_bytes.size() - 1);
				want.string_end = want.run_last && r.in_last;
				escaped_due.push_back(want);
			end
		end
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned pick_gap(input logic calm);
		int unsigned roll;
		if (calm) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end else if (roll < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 40);
	endfunction

	// ------------------------------------------------------------------
	// cycle limit
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// source driver
	// ------------------------------------------------------------------
	int unsigned src_gap = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_valid <= 1'b0;
			raw_data  <= '0;
			src_gap   <= 0;
		end else if (!raw_valid || !raw_stall) begin
			if (src_gap > 0) begin
				raw_valid <= 1'b0;
				src_gap   <= src_gap - 1;
			end else if (raw_pending.size() == 0) begin
				raw_valid <= 1'b0;
			end else if (raw_pending[0].drain_first && (raw_valid || !drained)) begin
				// hold the next string until every result is back
				raw_valid <= 1'b0;
			end else begin
				raw_valid <= 1'b1;
				raw_data  <= raw_pending[0].req;
				void'(raw_pending.pop_front());
				src_gap <= pick_gap(cycle_count[8:7] == 2'b01);
			end
		end
	end

	// ------------------------------------------------------------------
	// sink: random stalls plus long hold-offs so the block backs up
	// ------------------------------------------------------------------
	int unsigned sink_wait = 0;
	int unsigned sink_taken = 0;
	int unsigned choke_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_stall  <= 1'b0;
			sink_wait  <= 0;
			sink_taken <= 0;
			choke_left <= 0;
		end else begin
			if (esc_valid && !esc_stall) begin
				sink_taken <= sink_taken + 1;
			end
			if (choke_left > 0) begin
				esc_stall  <= 1'b1;
				choke_left <= choke_left - 1;
			end else if ((sink_taken == 100 || sink_taken == 500) && esc_valid && !esc_stall) begin
				esc_stall   <= 1'b1;
				choke_left  <= CHOKE_LEN;
				choke_count <= choke_count + 1;
			end else if (sink_wait > 0) begin
				esc_stall <= 1'b1;
				sink_wait <= sink_wait - 1;
			end else begin
				esc_stall <= 1'b0;
				sink_wait <= pick_gap(cycle_count[8:7] == 2'b10);
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on accepted requests, check accepted results
	// ------------------------------------------------------------------
	res_t want_res;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drained <= 1'b1;
		end else begin
			if (raw_valid && !raw_stall) begin
				escape_request(raw_data);
				bytes_taken <= bytes_taken + 1;
			end
			if (esc_valid && !esc_stall) begin
				if (escaped_due.size() == 0) begin
					$error("unexpected result: out_byte %02h has_byte %0b run_last %0b string_end %0b",
						esc_data.out_byte, esc_data.has_byte, esc_data.run_last,
						esc_data.string_end);
					fail_count++;
				end else begin
					want_res = escaped_due.pop_front();
					results_checked <= results_checked + 1;
					if (esc_data.has_byte !== want_res.has_byte) begin
						$error("has_byte mismatch: expected %0b, got %0b",
							want_res.has_byte, esc_data.has_byte);
						fail_count++;
					end else if (want_res.has_byte &&
						esc_data.out_byte !== want_res.out_byte) begin
						$error("out_byte mismatch: expected %02h, got %02h",
							want_res.out_byte, esc_data.out_byte);
						fail_count++;
					end
					if (esc_data.run_last !== want_res.run_last) begin
						$error("run_last mismatch: expected %0b, got %0b",
							want_res.run_last, esc_data.run_last);
						fail_count++;
					end
					if (esc_data.string_end !== want_res.string_end) begin
						$error("string_end mismatch: expected %0b, got %0b",
							want_res.string_end, esc_data.string_end);
						fail_count++;
					end
				end
			end
			drained <= (escaped_due.size() == 0);
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	function automatic void queue_raw(input logic [7:0] b, input logic lst,
		input logic drain);
		raw_item_t it;
		it.drain_first  = drain;
		it.req.in_byte  = b;
		it.req.in_last  = lst;
		raw_pending.push_back(it);
	endfunction

	initial begin : stimulus
		logic [7:0]  dir_bytes[26];
		logic [25:0] dir_ends;
		logic [7:0]  piece[$];
		logic [7:0]  lead;
		logic        noise;
		logic        ended;
		logic        drain_this;
		int unsigned kind;
		int unsigned len;
		int unsigned extra;
		int unsigned keep;
		int unsigned rnd_items;
		int unsigned strings;
		int unsigned drains;

		// directed part: escapes and control extremes ending in a dropped cr
		// (empty end), complete 2/3/4-byte sequences, stray bytes, a broken
		// sequence, a truncated sequence, and a lone lead as the last byte
		dir_bytes = '{8'h00, 8'h1F, CH_QUOTE, CH_BSLASH, CH_LF, CH_TAB, 8'h20, 8'h7F,
			CH_CR,
			8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'h80, 8'hFF, 8'hF8, 8'hC3, 8'h41, 8'hE2, 8'h82,
			8'hC3};
		dir_ends = '0;
		dir_ends[8]  = 1'b1;
		dir_ends[17] = 1'b1;
		dir_ends[24] = 1'b1;
		dir_ends[25] = 1'b1;
		for (int i = 0; i < 26; i++) begin
			queue_raw(dir_bytes[i], dir_ends[i], 1'b0);
		end
		strings = 4;
		drains  = 0;

		// random strings, mostly well formed with random content
		rnd_items = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			piece.delete();
			ended = 1'b0;
			noise = ($urandom_range(0, 9) == 0);
			len   = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
			for (int p = 0; p < len && !ended; p++) begin
				kind = $urandom_range(0, 99);
				if (noise) begin
					piece.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 35) begin
					piece.push_back(8'($urandom_range(32, 127)));
				end else if (kind < 45) begin
					case ($urandom_range(0, 4))
						0:       piece.push_back(CH_QUOTE);
						1:       piece.push_back(CH_BSLASH);
						2:       piece.push_back(CH_LF);
						3:       piece.push_back(CH_CR);
						default: piece.push_back(CH_TAB);
					endcase
				end else if (kind < 52) begin
					piece.push_back(8'($urandom_range(0, 31)));
				end else if (kind < 57) begin
					// stray: continuation byte or invalid lead
					if ($urandom_range(0, 1) == 0) begin
						piece.push_back({2'b10, 6'($urandom)});
					end else begin
						piece.push_back({5'b11111, 3'($urandom)});
					end
				end else begin
					extra = $urandom_range(1, 3);
					case (extra)
						1:       lead = {3'b110, 5'($urandom)};
						2:       lead = {4'b1110, 4'($urandom)};
						default: lead = {5'b11110, 3'($urandom)};
					endcase
					piece.push_back(lead);
					if (kind < 85) begin
						// complete sequence
						for (int k = 0; k < extra; k++) begin
							piece.push_back({2'b10, 6'($urandom)});
						end
					end else begin
						keep = $urandom_range(0, extra - 1);
						for (int k = 0; k < keep; k++) begin
							piece.push_back({2'b10, 6'($urandom)});
						end
						if (kind < 94) begin
							// broken: a non-continuation byte cuts it short
							kind = $urandom_range(0, 191);
							piece.push_back(kind >= 128 ? 8'(kind + 64) : 8'(kind));
						end else begin
							// truncated: the string ends here
							ended = 1'b1;
						end
					end
				end
			end
			drain_this = (strings == 4) || ($urandom_range(0, 14) == 0);
			if (drain_this) begin
				drains++;
			end
			foreach (piece[i]) begin
				queue_raw(piece[i], i == piece.size() - 1, drain_this && i == 0);
				// a dropped cr in mid-string does no work
				if (!(piece[i] == CH_CR && i != piece.size() - 1)) begin
					rnd_items++;
				end
			end
			strings++;
		end

		@(posedge arst_n);
		// all requests handed over
		do begin
			@(posedge clk);
		end while (raw_pending.size() != 0 || raw_valid);
		// all results back, then let any stray output show up
		while (!drained) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
		if (escaped_due.size() != 0) begin
			$error("%0d escaped results never arrived", escaped_due.size());
			fail_count++;
		end

		$display("covered %0d strings, %0d raw bytes in, %0d escaped results checked",
			strings, bytes_taken, results_checked);
		$display("receiver hold-offs: %0d, sender drain pauses: %0d", choke_count, drains);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/jesu_pkg.sv
rtl/jesu_ctrl.sv
rtl/jesu_dp.sv
rtl/json_escape_utf8_sanitizer_unit.sv
bench/testbench.sv
